FILE: hw/rtl/bbd_pkg.sv
// shared types and constants for the banked bus decoder
`timescale 1ns / 1ps

package bbd_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REPLY  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  // decoded region of a bus access
  typedef enum logic [2:0] {
    REG_RAM  = 3'd0,
    REG_ROM  = 3'd1,
    REG_UART = 3'd2,
    REG_SD   = 3'd3,
    REG_MAP  = 3'd4,
    REG_NONE = 3'd5
  } region_e;

  // chip-select events of the sd port
  typedef enum logic [1:0] {
    CS_NONE  = 2'd0,
    CS_RAISE = 2'd1,
    CS_LOWER = 2'd2
  } cs_e;

  localparam int unsigned PhysW = 20;

  localparam logic [15:0] RomMask    = 16'hF000;
  localparam logic [15:0] WinMask    = 16'hF800;
  localparam logic [15:0] IoBase     = 16'hE000;
  localparam logic [15:0] MapBase    = 16'hE800;
  localparam logic [15:0] IoSelMask  = 16'h0070;
  localparam logic [15:0] UartSel    = 16'h0000;
  localparam logic [15:0] SdSel      = 16'h0010;
  localparam logic [3:0]  IoNibble   = 4'hE;
  localparam logic [7:0]  FloatByte  = 8'hFF;

  // sd port bit positions
  localparam int unsigned SsBit   = 7;
  localparam int unsigned MosiBit = 6;
  localparam int unsigned SckBit  = 5;
  localparam logic [3:0]  BitsPerByte = 4'd8;

  // control from the decoder to the sd port
  typedef struct packed {
    logic       reply_load;
    logic       port_write;
    logic [7:0] wdata;
    logic [7:0] card_byte;
  } sd_req_t;

  // what the sd port reports back for one request
  typedef struct packed {
    cs_e        cs_event;
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic [7:0] port_in;
  } sd_rsp_t;

endpackage

FILE: hw/rtl/bbd_sd_port.sv
// bit-bang sd port: latch, chip-select tracking and spi shifters
`timescale 1ns / 1ps

module bbd_sd_port (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  bbd_pkg::sd_req_t req_i,
  output bbd_pkg::sd_rsp_t rsp_o
);

  logic [7:0] port_out_q, port_out_d;
  logic [7:0] port_in_q, port_in_d;
  logic [3:0] bit_count_q, bit_count_d;
  logic [7:0] tx_shift_q, tx_shift_d;
  logic [7:0] rx_shift_q, rx_shift_d;

  logic [7:0] delta;
  logic [3:0] count_inc;

  assign delta = req_i.wdata ^ port_out_q;

  always_comb begin
    port_out_d  = port_out_q;
    port_in_d   = port_in_q;
    bit_count_d = bit_count_q;
    tx_shift_d  = tx_shift_q;
    rx_shift_d  = rx_shift_q;
    count_inc   = 4'd0;

    rsp_o.cs_event  = bbd_pkg::CS_NONE;
    rsp_o.spi_valid = 1'b0;
    rsp_o.spi_byte  = 8'd0;
    rsp_o.port_in   = port_in_q;

    if (req_i.reply_load) begin
      rx_shift_d = req_i.card_byte;
    end else if (req_i.port_write) begin
      port_out_d = req_i.wdata;
      if (delta[bbd_pkg::SsBit]) begin
        if (req_i.wdata[bbd_pkg::SsBit]) begin
          // deselect resets the bit counter before any clock edge
          bit_count_d    = 4'd0;
          rsp_o.cs_event = bbd_pkg::CS_RAISE;
        end else begin
          rsp_o.cs_event = bbd_pkg::CS_LOWER;
        end
      end
      if (delta[bbd_pkg::SckBit]) begin
        if (req_i.wdata[bbd_pkg::SckBit]) begin
          tx_shift_d = {tx_shift_q[6:0], req_i.wdata[bbd_pkg::MosiBit]};
          count_inc  = bit_count_d + 4'd1;
          bit_count_d = count_inc;
          if (count_inc == bbd_pkg::BitsPerByte) begin
            rsp_o.spi_valid = 1'b1;
            rsp_o.spi_byte  = tx_shift_d;
            bit_count_d     = 4'd0;
          end
        end else begin
          // falling clock samples the reply into the miso bit
          port_in_d  = {port_in_q[7], rx_shift_q[6], port_in_q[5:0]};
          rx_shift_d = {rx_shift_q[6:0], 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_out_q  <= 8'd0;
      port_in_q   <= 8'd0;
      bit_count_q <= 4'd0;
      tx_shift_q  <= 8'd0;
      rx_shift_q  <= 8'd0;
    end else if (en_i) begin
      port_out_q  <= port_out_d;
      port_in_q   <= port_in_d;
      bit_count_q <= bit_count_d;
      tx_shift_q  <= tx_shift_d;
      rx_shift_q  <= rx_shift_d;
    end
  end

endmodule

FILE: hw/rtl/banked_bus_decoder_with_bitbang_spi.sv
// top level: banked bus decoder with bit-bang sd port
`timescale 1ns / 1ps

// Decodes CPU bus requests into RAM, ROM, UART, SD port and page register
// accesses, and runs a bit-bang SPI port for an SD card.
// Input channel: in_valid_i / in_stall_o with cmd_i, addr_i, wdata_i,
// debug_read_i and card_byte_i; a request is taken on an edge with valid
// high and stall low. cmd 2 delivers the card's reply byte.
// Output channel: out_valid_o / out_stall_i with one result per request:
// region, physical address, write strobe, local read data, chip-select
// event and any byte clocked out to the card.
// A request sits in the input register and its result leaves from the result
// register. Throughput is one request per cycle while the receiver does not
// stall, set by the single decode-and-update pass. When the receiver stalls,
// the result register holds and the input register still takes one more
// request; stall reaches the sender only when both are full. Page register
// and port state update as a request moves into the result register, so
// requests act strictly in order. Reset clears the page register, port
// latch, shifters and bit counter and empties both registers.

module banked_bus_decoder_with_bitbang_spi #(
  parameter int unsigned PAGE_BITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        debug_read_i,
  input  logic [7:0]  card_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  region_o,
  output logic [19:0] phys_addr_o,
  output logic        mem_write_o,
  output logic [7:0]  local_rdata_o,
  output logic [1:0]  cs_event_o,
  output logic        spi_valid_o,
  output logic [7:0]  spi_byte_o
);

  localparam int unsigned ExtW = PAGE_BITS + 15 + bbd_pkg::PhysW;

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  cmd_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic        dbg_q;
  logic [7:0]  card_q;

  // result register
  logic                s2_valid_q, s2_valid_d;
  bbd_pkg::region_e    region_q, region_d;
  logic [19:0]         phys_q, phys_d;
  logic                mw_q, mw_d;
  logic [7:0]          rdata_q, rdata_d;
  bbd_pkg::cs_e        cs_q;
  logic                sv_q;
  logic [7:0]          sb_q;

  logic [PAGE_BITS-1:0] page_q, page_d;

  logic in_take, s2_load, out_take;
  logic [ExtW-1:0] paged_ext;
  logic [19:0]     paged_addr;

  bbd_pkg::sd_req_t sd_req;
  bbd_pkg::sd_rsp_t sd_rsp;

  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = s2_valid_q && !out_stall_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (out_take) begin
      s2_valid_d = 1'b0;
    end
  end

  // page bits above the 20-bit physical space fall away
  assign paged_ext  = {{bbd_pkg::PhysW{1'b0}}, page_q, addr_q[14:0]};
  assign paged_addr = paged_ext[19:0];

  always_comb begin
    region_d = bbd_pkg::REG_NONE;
    phys_d   = 20'd0;
    mw_d     = 1'b0;
    rdata_d  = 8'd0;
    page_d   = page_q;
    sd_req.reply_load = 1'b0;
    sd_req.port_write = 1'b0;
    sd_req.wdata      = wdata_q;
    sd_req.card_byte  = card_q;

    unique case (bbd_pkg::cmd_e'(cmd_q))
      bbd_pkg::CMD_REPLY: begin
        sd_req.reply_load = 1'b1;
      end
      bbd_pkg::CMD_READ: begin
        if (addr_q[15:12] == bbd_pkg::IoNibble && dbg_q) begin
          rdata_d = bbd_pkg::FloatByte;
        end else if ((addr_q & bbd_pkg::RomMask) == bbd_pkg::RomMask) begin
          region_d = bbd_pkg::REG_ROM;
          phys_d   = {8'd0, addr_q[11:0]};
        end else if ((addr_q & bbd_pkg::WinMask) == bbd_pkg::IoBase) begin
          if ((addr_q & bbd_pkg::IoSelMask) == bbd_pkg::UartSel) begin
            region_d = bbd_pkg::REG_UART;
            phys_d   = {17'd0, addr_q[2:0]};
          end else if ((addr_q & bbd_pkg::IoSelMask) == bbd_pkg::SdSel) begin
            region_d = bbd_pkg::REG_SD;
            rdata_d  = sd_rsp.port_in;
          end else begin
            rdata_d = bbd_pkg::FloatByte;
          end
        end else if (addr_q[15]) begin
          // fixed ram, also covers reads of the page register window
          region_d = bbd_pkg::REG_RAM;
          phys_d   = {4'd0, addr_q};
        end else begin
          region_d = bbd_pkg::REG_RAM;
          phys_d   = paged_addr;
        end
      end
      bbd_pkg::CMD_WRITE: begin
        if ((addr_q & bbd_pkg::RomMask) == bbd_pkg::RomMask) begin
          region_d = bbd_pkg::REG_ROM;
          phys_d   = {8'd0, addr_q[11:0]};
        end else if ((addr_q & bbd_pkg::WinMask) == bbd_pkg::IoBase) begin
          if ((addr_q & bbd_pkg::IoSelMask) == bbd_pkg::UartSel) begin
            region_d = bbd_pkg::REG_UART;
            phys_d   = {17'd0, addr_q[2:0]};
            mw_d     = 1'b1;
          end else if ((addr_q & bbd_pkg::IoSelMask) == bbd_pkg::SdSel) begin
            region_d          = bbd_pkg::REG_SD;
            sd_req.port_write = 1'b1;
          end
        end else if ((addr_q & bbd_pkg::WinMask) == bbd_pkg::MapBase) begin
          region_d = bbd_pkg::REG_MAP;
          page_d   = wdata_q[PAGE_BITS-1:0];
        end else if (addr_q[15]) begin
          region_d = bbd_pkg::REG_RAM;
          phys_d   = {4'd0, addr_q};
          mw_d     = 1'b1;
        end else begin
          region_d = bbd_pkg::REG_RAM;
          phys_d   = paged_addr;
          mw_d     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  bbd_sd_port u_sd_port (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s2_load),
    .req_i  (sd_req),
    .rsp_o  (sd_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      page_q     <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s2_load) begin
        page_q <= page_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= cmd_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
      dbg_q   <= debug_read_i;
      card_q  <= card_byte_i;
    end
    if (s2_load) begin
      region_q <= region_d;
      phys_q   <= phys_d;
      mw_q     <= mw_d;
      rdata_q  <= rdata_d;
      cs_q     <= sd_rsp.cs_event;
      sv_q     <= sd_rsp.spi_valid;
      sb_q     <= sd_rsp.spi_byte;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign region_o      = region_q;
  assign phys_addr_o   = phys_q;
  assign mem_write_o   = mw_q;
  assign local_rdata_o = rdata_q;
  assign cs_event_o    = cs_q;
  assign spi_valid_o   = sv_q;
  assign spi_byte_o    = sb_q;

`ifndef SYNTHESIS
  // port activity only ever comes from an sd port request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && (sv_q || cs_q != bbd_pkg::CS_NONE) |-> region_q == bbd_pkg::REG_SD)
    else $error("sd port event outside the sd port region");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && mw_q |-> region_q == bbd_pkg::REG_RAM || region_q == bbd_pkg::REG_UART)
    else $error("write strobe for a region that takes no data");

  // the sender is held off only when both registers are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // a request left the input register, so a result must be pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> s2_valid_q)
    else $error("result lost on load");
`endif

endmodule

FILE: tb/banked_bus_decoder_with_bitbang_spi_test.sv
// self-checking testbench for the banked bus decoder with bit-bang sd port
`timescale 1ns / 1ps

module banked_bus_decoder_with_bitbang_spi_test;

  // no acceptance on either side for this long means the block is stuck
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned TailCycles = 8;

  typedef struct packed {
    bbd_pkg::region_e region;
    logic [19:0]      phys_addr;
    logic             mem_write;
    logic [7:0]       local_rdata;
    bbd_pkg::cs_e     cs_event;
    logic             spi_valid;
    logic [7:0]       spi_byte;
  } bus_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = bbd_pkg::CMD_READ;
  logic [15:0] addr_i = 16'h0000;
  logic [7:0]  wdata_i = 8'h00;
  logic        debug_read_i = 1'b0;
  logic [7:0]  card_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  region_o;
  logic [19:0] phys_addr_o;
  logic        mem_write_o;
  logic [7:0]  local_rdata_o;
  logic [1:0]  cs_event_o;
  logic        spi_valid_o;
  logic [7:0]  spi_byte_o;

  // predictor state
  logic [4:0] page_sel;
  logic [7:0] port_latch;
  logic [7:0] port_rd;
  logic [3:0] sck_count;
  logic [7:0] mosi_sr;
  logic [7:0] miso_sr;

  bus_result_t pending_decodes[$];

  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 80;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_clocked = 0;
  int unsigned cs_events_seen = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  banked_bus_decoder_with_bitbang_spi u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .addr_i        (addr_i),
    .wdata_i       (wdata_i),
    .debug_read_i  (debug_read_i),
    .card_byte_i   (card_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .region_o      (region_o),
    .phys_addr_o   (phys_addr_o),
    .mem_write_o   (mem_write_o),
    .local_rdata_o (local_rdata_o),
    .cs_event_o    (cs_event_o),
    .spi_valid_o   (spi_valid_o),
    .spi_byte_o    (spi_byte_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // decodes one request and advances the page register and sd port state
  function automatic bus_result_t decode_request(input bbd_pkg::cmd_e c,
                                                 input logic [15:0] a,
                                                 input logic [7:0] wd, input logic dbg,
                                                 input logic [7:0] cb);
    bus_result_t r;
    logic [7:0] flip;
    r = '0;
    r.region = bbd_pkg::REG_NONE;
    r.cs_event = bbd_pkg::CS_NONE;
    case (c)
      bbd_pkg::CMD_REPLY: miso_sr = cb;
      bbd_pkg::CMD_READ: begin
        if (a[15:12] == bbd_pkg::IoNibble && dbg) begin
          r.local_rdata = bbd_pkg::FloatByte;
        end else if ((a & bbd_pkg::RomMask) == bbd_pkg::RomMask) begin
          r.region = bbd_pkg::REG_ROM;
          r.phys_addr = {8'h00, a[11:0]};
        end else if ((a & bbd_pkg::WinMask) == bbd_pkg::IoBase) begin
          if ((a & bbd_pkg::IoSelMask) == bbd_pkg::UartSel) begin
            r.region = bbd_pkg::REG_UART;
            r.phys_addr = {17'h0, a[2:0]};
          end else if ((a & bbd_pkg::IoSelMask) == bbd_pkg::SdSel) begin
            r.region = bbd_pkg::REG_SD;
            r.local_rdata = port_rd;
          end else begin
            r.local_rdata = bbd_pkg::FloatByte;
          end
        end else if (a[15]) begin
          r.region = bbd_pkg::REG_RAM;
          r.phys_addr = {4'h0, a};
        end else begin
          r.region = bbd_pkg::REG_RAM;
          r.phys_addr = {page_sel, a[14:0]};
        end
      end
      bbd_pkg::CMD_WRITE: begin
        if ((a & bbd_pkg::RomMask) == bbd_pkg::RomMask) begin
          r.region = bbd_pkg::REG_ROM;
          r.phys_addr = {8'h00, a[11:0]};
        end else if ((a & bbd_pkg::WinMask) == bbd_pkg::IoBase) begin
          if ((a & bbd_pkg::IoSelMask) == bbd_pkg::UartSel) begin
            r.region = bbd_pkg::REG_UART;
            r.phys_addr = {17'h0, a[2:0]};
            r.mem_write = 1'b1;
          end else if ((a & bbd_pkg::IoSelMask) == bbd_pkg::SdSel) begin
            flip = wd ^ port_latch;
            r.region = bbd_pkg::REG_SD;
            port_latch = wd;
            if (flip[bbd_pkg::SsBit]) begin
              // deselect resets the bit counter before any clock edge in this write
              if (wd[bbd_pkg::SsBit]) begin
                sck_count = 4'd0;
                r.cs_event = bbd_pkg::CS_RAISE;
              end else begin
                r.cs_event = bbd_pkg::CS_LOWER;
              end
            end
            if (flip[bbd_pkg::SckBit]) begin
              if (wd[bbd_pkg::SckBit]) begin
                mosi_sr = {mosi_sr[6:0], wd[bbd_pkg::MosiBit]};
                sck_count = sck_count + 4'd1;
                if (sck_count == bbd_pkg::BitsPerByte) begin
                  r.spi_valid = 1'b1;
                  r.spi_byte = mosi_sr;
                  sck_count = 4'd0;
                end
              end else begin
                port_rd[bbd_pkg::MosiBit] = miso_sr[bbd_pkg::MosiBit];
                miso_sr = {miso_sr[6:0], 1'b1};
              end
            end
          end
        end else if ((a & bbd_pkg::WinMask) == bbd_pkg::MapBase) begin
          r.region = bbd_pkg::REG_MAP;
          page_sel = wd[4:0];
        end else if (a[15]) begin
          r.region = bbd_pkg::REG_RAM;
          r.phys_addr = {4'h0, a};
          r.mem_write = 1'b1;
        end else begin
          r.region = bbd_pkg::REG_RAM;
          r.phys_addr = {page_sel, a[14:0]};
          r.mem_write = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input bbd_pkg::cmd_e c, input logic [15:0] a,
                              input logic [7:0] wd, input logic dbg,
                              input logic [7:0] cb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    addr_i       <= a;
    wdata_i      <= wd;
    debug_read_i <= dbg;
    card_byte_i  <= cb;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_decodes.push_back(decode_request(c, a, wd, dbg, cb));
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_decodes.size() != 0);
  endtask

  function automatic logic [15:0] sd_port_addr();
    logic [15:0] a;
    a = 16'($urandom);
    a[15:11] = 5'b11100;
    a[6:4] = 3'b001;
    return a;
  endfunction

  task automatic port_write(input logic ss, input logic mosi, input logic sck);
    logic [4:0] pad;
    pad = 5'($urandom);
    send_request(bbd_pkg::CMD_WRITE, sd_port_addr(), {ss, mosi, sck, pad},
                 $urandom_range(1) == 1, 8'($urandom));
  endtask

  task automatic send_bus_access();
    logic [15:0] a;
    a = 16'($urandom);
    case ($urandom_range(6))
      0: a[15] = 1'b0;
      1: begin
        a[15] = 1'b1;
        if (a[14:13] == 2'b11) a[14] = 1'b0;
      end
      2: a[15:11] = 5'b11101;
      3: a[15:12] = 4'hF;
      4: begin
        a[15:11] = 5'b11100;
        a[6:5] = 2'b00;
      end
      5: a[15:11] = 5'b11100;
      default: ;
    endcase
    send_request(bbd_pkg::cmd_e'($urandom_range(1)), a, 8'($urandom),
                 $urandom_range(3) == 0, 8'($urandom));
  endtask

  // one card transaction: reply byte, select, one byte clocked out msb first, port read back
  task automatic send_spi_byte();
    logic [7:0] mosi_byte;
    mosi_byte = 8'($urandom);
    if ($urandom_range(7) != 0)
      send_request(bbd_pkg::CMD_REPLY, 16'($urandom), 8'($urandom),
                   $urandom_range(1) == 1, 8'($urandom));
    if ($urandom_range(1) == 1) port_write(1'b1, $urandom_range(1) == 1, 1'b0);
    port_write(1'b0, $urandom_range(1) == 1, 1'b0);
    for (int i = 7; i >= 0; i--) begin
      port_write(1'b0, mosi_byte[i], 1'b1);
      if ($urandom_range(5) == 0)
        send_request(bbd_pkg::CMD_READ, sd_port_addr(), 8'($urandom), 1'b0,
                     8'($urandom));
      else if ($urandom_range(7) == 0)
        send_bus_access();
      port_write(1'b0, $urandom_range(1) == 1, 1'b0);
    end
    send_request(bbd_pkg::CMD_READ, sd_port_addr(), 8'($urandom), 1'b0, 8'($urandom));
    if ($urandom_range(1) == 1) port_write(1'b1, $urandom_range(1) == 1, 1'b0);
  endtask

  task automatic test_memory_map();
    send_request(bbd_pkg::CMD_READ,   16'h0000, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE,  16'h7FFF, 8'hFF, 1'b0, 8'hFF);
    // debug flag on a write has no effect
    send_request(bbd_pkg::CMD_WRITE,  16'hE800, 8'hFF, 1'b1, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'h7FFF, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'h0000, 8'h00, 1'b1, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'h8000, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE,  16'hDFFF, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'hEFFF, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'hF000, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE,  16'hFFFF, 8'hA5, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE,  16'hE007, 8'h5A, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'hE000, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'hE7FF, 8'h00, 1'b1, 8'h00);
    send_request(bbd_pkg::CMD_READ,   16'hE020, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE,  16'hE07F, 8'h55, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 8'hFF);
    send_request(bbd_pkg::CMD_WRITE,  16'hEFFF, 8'hE0, 1'b0, 8'h00);
  endtask

  task automatic test_sd_port();
    send_request(bbd_pkg::CMD_REPLY, 16'h0000, 8'h00, 1'b0, 8'hC3);
    send_request(bbd_pkg::CMD_READ,  16'hE010, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE, 16'hE010, 8'h80, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE, 16'hE01F, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE, 16'hE010, 8'h60, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_WRITE, 16'hE010, 8'h00, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,  16'hE01F, 8'h00, 1'b0, 8'h00);
    // deselect together with a rising clock
    send_request(bbd_pkg::CMD_WRITE, 16'hE010, 8'hA0, 1'b0, 8'h00);
    send_request(bbd_pkg::CMD_READ,  16'hE010, 8'h00, 1'b1, 8'h00);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned first;
    bit paused;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = requests_sent;
    paused = 1'b0;
    while (requests_sent - first < n) begin
      if (!paused && requests_sent - first >= n / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      case ($urandom_range(9))
        0, 1, 2: send_spi_byte();
        3, 4, 5, 6: send_bus_access();
        7: send_request(bbd_pkg::CMD_WRITE, {5'b11101, 11'($urandom)}, 8'($urandom),
                        $urandom_range(1) == 1, 8'($urandom));
        default: send_request(bbd_pkg::cmd_e'($urandom_range(3)), 16'($urandom),
                              8'($urandom), $urandom_range(1) == 1, 8'($urandom));
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    bus_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_decodes.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        want = pending_decodes.pop_front();
        check_field("region", 32'(want.region), 32'(region_o));
        check_field("phys_addr", 32'(want.phys_addr), 32'(phys_addr_o));
        check_field("mem_write", 32'(want.mem_write), 32'(mem_write_o));
        check_field("local_rdata", 32'(want.local_rdata), 32'(local_rdata_o));
        check_field("cs_event", 32'(want.cs_event), 32'(cs_event_o));
        check_field("spi_valid", 32'(want.spi_valid), 32'(spi_valid_o));
        check_field("spi_byte", 32'(want.spi_byte), 32'(spi_byte_o));
        results_checked++;
        if (want.spi_valid) bytes_clocked++;
        if (want.cs_event != bbd_pkg::CS_NONE) cs_events_seen++;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    page_sel   = '0;
    port_latch = '0;
    port_rd    = '0;
    sck_count  = '0;
    mosi_sr    = '0;
    miso_sr    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_memory_map();
    test_sd_port();
    test_random_traffic(170, 32, 80);
    test_random_traffic(170, 80, 32);
    test_random_traffic(160, 0, 0);
    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d requests across ram, rom, uart, page register and sd port",
             requests_sent);
    $display("checked %0d results, %0d bytes clocked out, %0d chip-select events",
             results_checked, bytes_clocked, cs_events_seen);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
